@@ src/gift128_block_cipher_macros.svh @@
// assertion macros shared by the cipher rtl
`ifndef GIFT128_BLOCK_CIPHER_MACROS_SVH
`define GIFT128_BLOCK_CIPHER_MACROS_SVH

// same-cycle implication, checked outside reset
`define GIFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GIFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/gift_pkg.sv @@
// shared types, constants and bit-level functions for the gift-128 core
`timescale 1ns / 1ps
`default_nettype none
package gift_pkg;

  localparam int BLK_W = 128;
  localparam int HALF_W = 64;
  localparam int RC_W = 6;
  localparam int NIB_N = 32;

  // constant lfsr value used by the first round
  localparam logic [RC_W-1:0] RC_INIT = 6'h01;
  localparam logic [RC_W-1:0] RC_MASK = 6'h3F;

  typedef struct packed {
    logic load;
    logic fwd;
    logic inv;
  } ks_ctrl_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'h1;
      4'h1: r = 4'ha;
      4'h2: r = 4'h4;
      4'h3: r = 4'hc;
      4'h4: r = 4'h6;
      4'h5: r = 4'hf;
      4'h6: r = 4'h3;
      4'h7: r = 4'h9;
      4'h8: r = 4'h2;
      4'h9: r = 4'hd;
      4'ha: r = 4'hb;
      4'hb: r = 4'h7;
      4'hc: r = 4'h5;
      4'hd: r = 4'h0;
      4'he: r = 4'h8;
      4'hf: r = 4'he;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'hd;
      4'h1: r = 4'h0;
      4'h2: r = 4'h8;
      4'h3: r = 4'h6;
      4'h4: r = 4'h2;
      4'h5: r = 4'hc;
      4'h6: r = 4'h4;
      4'h7: r = 4'hb;
      4'h8: r = 4'he;
      4'h9: r = 4'h7;
      4'ha: r = 4'h1;
      4'hb: r = 4'ha;
      4'hc: r = 4'h3;
      4'hd: r = 4'h9;
      4'he: r = 4'hf;
      4'hf: r = 4'h5;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  // destination of state bit i under the bit permutation
  function automatic logic [6:0] perm_pos(input logic [6:0] i);
    logic [2:0] q;
    logic [1:0] g;
    logic [1:0] b;
    logic [1:0] m;
    q = i[6:4];
    g = i[3:2];
    b = i[1:0];
    m = 2'(({g, 1'b0} + g) + b);
    return {m, q, b};
  endfunction

  function automatic logic [BLK_W-1:0] perm_fwd(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    t = '0;
    for (int i = 0; i < BLK_W; i++) begin
      t[perm_pos(7'(i))] = s[i];
    end
    return t;
  endfunction

  function automatic logic [BLK_W-1:0] perm_inv(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    t = '0;
    for (int i = 0; i < BLK_W; i++) begin
      t[i] = s[perm_pos(7'(i))];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ src/gift128_block_cipher.sv @@
// gift-128 block cipher core: one round per cycle on a shared round datapath
// encrypt: busy for ROUNDS rounds, result strobed on out_valid in the cycle after the last
// decrypt: first runs the key schedule forward to the last round key, then ROUNDS rounds
// one block at a time; start is taken again in the cycle the result shows
// the key schedule steps once per cycle while busy, the round datapath once per cycle while running rounds
// synchronous active-low reset clears fsm, counter, out_valid and key config registers to zero
`timescale 1ns / 1ps
`default_nettype none
`include "gift128_block_cipher_macros.svh"
module gift128_block_cipher import gift_pkg::*; #(
  parameter int ROUNDS = 40
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_action,
  input  wire logic [HALF_W-1:0] in_block_low,
  input  wire logic [HALF_W-1:0] in_block_high,
  output logic                   out_valid,
  output logic      [HALF_W-1:0] out_result_low,
  output logic      [HALF_W-1:0] out_result_high,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [HALF_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(ROUNDS + 1);
  localparam logic [CNT_W-1:0] RUN_LAST  = CNT_W'(ROUNDS - 1);
  localparam logic [CNT_W-1:0] PREP_LAST = CNT_W'((ROUNDS > 1) ? (ROUNDS - 2) : 0);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  logic [1:0]        fsm_r;
  logic [1:0]        fsm_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              dir_r;
  logic              dir_nxt;
  logic [BLK_W-1:0]  blk_r;
  logic [BLK_W-1:0]  blk_nxt;
  logic [HALF_W-1:0] key_low_r;
  logic [HALF_W-1:0] key_high_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BLK_W-1:0]  res_r;
  logic [BLK_W-1:0]  res_nxt;
  logic              accept;
  ks_ctrl_t          ks_ctrl;
  logic [31:0]       rk_u;
  logic [31:0]       rk_v;
  logic [RC_W-1:0]   rc;
  logic [BLK_W-1:0]  round_out;

  assign busy   = (fsm_r != ST_IDLE);
  assign accept = start && !busy;

  gift_keysched u_keysched (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ks_ctrl),
    .key_in ({key_high_r, key_low_r}),
    .rk_u   (rk_u),
    .rk_v   (rk_v),
    .rc     (rc)
  );

  gift_round u_round (
    .decrypt   (dir_r),
    .state_in  (blk_r),
    .rk_u      (rk_u),
    .rk_v      (rk_v),
    .rc        (rc),
    .state_out (round_out)
  );

  always_comb begin
    fsm_nxt       = fsm_r;
    cnt_nxt       = cnt_r;
    dir_nxt       = dir_r;
    blk_nxt       = blk_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    ks_ctrl       = '0;
    case (fsm_r)
      ST_IDLE: begin
        if (start) begin
          ks_ctrl.load = 1'b1;
          dir_nxt      = in_action;
          blk_nxt      = {in_block_high, in_block_low};
          cnt_nxt      = '0;
          // decryption first walks the key schedule to the last round key
          fsm_nxt      = (in_action && (ROUNDS > 1)) ? ST_PREP : ST_RUN;
        end
      end
      ST_PREP: begin
        ks_ctrl.fwd = 1'b1;
        if (cnt_r == PREP_LAST) begin
          cnt_nxt = '0;
          fsm_nxt = ST_RUN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RUN: begin
        ks_ctrl.fwd = !dir_r;
        ks_ctrl.inv = dir_r;
        blk_nxt     = round_out;
        if (cnt_r == RUN_LAST) begin
          res_nxt       = round_out;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          fsm_nxt       = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        fsm_nxt = ST_IDLE;
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    res_r <= res_nxt;
    dir_r <= dir_nxt;
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_low  = res_r[HALF_W-1:0];
  assign out_result_high = res_r[BLK_W-1:HALF_W];

  `GIFT_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted block did not raise busy")
  `GIFT_ASSERT_NEXT(a_last_strobe, clk, rst_n, (fsm_r == ST_RUN) && (cnt_r == RUN_LAST), out_valid, "last round did not strobe a result")
  `GIFT_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy, "result strobed while still busy")
  `GIFT_ASSERT_NOW(a_cnt_range, clk, rst_n, busy, cnt_r <= RUN_LAST, "round counter out of range")

endmodule
`default_nettype wire

@@ src/gift_round.sv @@
// one shared gift-128 round datapath, forward or inverse
`timescale 1ns / 1ps
`default_nettype none
module gift_round import gift_pkg::*; (
  input  wire logic             decrypt,
  input  wire logic [BLK_W-1:0] state_in,
  input  wire logic [31:0]      rk_u,
  input  wire logic [31:0]      rk_v,
  input  wire logic [RC_W-1:0]  rc,
  output logic      [BLK_W-1:0] state_out
);

  logic [BLK_W-1:0] rk_mask;
  logic [BLK_W-1:0] sub_fwd;
  logic [BLK_W-1:0] enc_out;
  logic [BLK_W-1:0] dec_perm;
  logic [BLK_W-1:0] dec_out;

  // round key on bits 4i+2 / 4i+1, constant on bits 4i+3, top bit flipped
  always_comb begin
    rk_mask = '0;
    for (int i = 0; i < 32; i++) begin
      rk_mask[4*i+2] = rk_u[i];
      rk_mask[4*i+1] = rk_v[i];
    end
    for (int i = 0; i < RC_W; i++) begin
      rk_mask[4*i+3] = rc[i];
    end
    rk_mask[BLK_W-1] = 1'b1;
  end

  always_comb begin
    for (int j = 0; j < NIB_N; j++) begin
      sub_fwd[4*j +: 4] = sbox_fwd(state_in[4*j +: 4]);
    end
  end

  assign enc_out  = perm_fwd(sub_fwd) ^ rk_mask;
  assign dec_perm = perm_inv(state_in ^ rk_mask);

  always_comb begin
    for (int j = 0; j < NIB_N; j++) begin
      dec_out[4*j +: 4] = sbox_inv(dec_perm[4*j +: 4]);
    end
  end

  assign state_out = decrypt ? dec_out : enc_out;

endmodule
`default_nettype wire

@@ src/gift_keysched.sv @@
// key schedule and round constant registers, stepping forward or backward
`timescale 1ns / 1ps
`default_nettype none
module gift_keysched import gift_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ks_ctrl_t         ctrl,
  input  wire logic [BLK_W-1:0] key_in,
  output logic      [31:0]      rk_u,
  output logic      [31:0]      rk_v,
  output logic      [RC_W-1:0]  rc
);

  logic [BLK_W-1:0] key_r;
  logic [BLK_W-1:0] key_nxt;
  logic [RC_W-1:0]  rc_r;
  logic [RC_W-1:0]  rc_nxt;
  logic [15:0]      k0;
  logic [15:0]      k1;
  logic [15:0]      k6;
  logic [15:0]      k7;
  logic [BLK_W-1:0] key_fwd;
  logic [BLK_W-1:0] key_inv;
  logic [RC_W-1:0]  rc_fwd;
  logic [RC_W-1:0]  rc_inv;

  assign k0 = key_r[15:0];
  assign k1 = key_r[31:16];
  assign k6 = key_r[111:96];
  assign k7 = key_r[127:112];

  // forward: k1 >>> 2, k0 >>> 12 on top, words shift down by two
  assign key_fwd = {k1[1:0], k1[15:2], k0[11:0], k0[15:12], key_r[127:32]};
  // backward: undo the rotations and shift words back up
  assign key_inv = {key_r[95:0], k7[13:0], k7[15:14], k6[3:0], k6[15:4]};

  assign rc_fwd = ({rc_r[RC_W-2:0], 1'b0} & RC_MASK)
                | {5'b0, rc_r[5] ^ rc_r[4] ^ 1'b1};
  assign rc_inv = {rc_r[0] ^ rc_r[5] ^ 1'b1, rc_r[5:1]};

  always_comb begin
    key_nxt = key_r;
    rc_nxt  = rc_r;
    if (ctrl.load) begin
      key_nxt = key_in;
      rc_nxt  = RC_INIT;
    end else if (ctrl.fwd) begin
      key_nxt = key_fwd;
      rc_nxt  = rc_fwd;
    end else if (ctrl.inv) begin
      key_nxt = key_inv;
      rc_nxt  = rc_inv;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      rc_r <= RC_INIT;
    end else begin
      rc_r <= rc_nxt;
    end
  end

  assign rk_u = key_r[95:64];
  assign rk_v = key_r[31:0];
  assign rc   = rc_r;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// self-checking testbench for the gift-128 block cipher core
`timescale 1ns / 1ps
module tb;
  import gift_pkg::HALF_W;
  import gift_pkg::BLK_W;

  localparam int ROUNDS = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 170;
  localparam bit ACT_ENC = 1'b0;
  localparam bit ACT_DEC = 1'b1;
  localparam bit REG_KEY_LOW = 1'b0;
  localparam bit REG_KEY_HIGH = 1'b1;
  // nibble n holds the s-box output for input n
  localparam logic [63:0] SBOX_NIBS = 64'he805_7bd2_93f6_c4a1;

  typedef struct packed {
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } block_t;

  class gift_scoreboard;
    logic [HALF_W-1:0] key_lo = '0;
    logic [HALF_W-1:0] key_hi = '0;
    block_t expected_q[$];
    int errors = 0;

    function void write_reg(bit idx, logic [HALF_W-1:0] val);
      if (idx == REG_KEY_LOW) begin
        key_lo = val;
      end else begin
        key_hi = val;
      end
    endfunction

    function logic [3:0] sbox(logic [3:0] n, bit inv);
      logic [3:0] r;
      r = SBOX_NIBS[4*int'(n) +: 4];
      if (inv) begin
        for (int v = 0; v < 16; v++) begin
          if (SBOX_NIBS[4*v +: 4] == n) r = 4'(v);
        end
      end
      return r;
    endfunction

    function logic [BLK_W-1:0] sub_layer(logic [BLK_W-1:0] s, bit inv);
      logic [BLK_W-1:0] t;
      for (int n = 0; n < 32; n++) t[4*n +: 4] = sbox(s[4*n +: 4], inv);
      return t;
    endfunction

    function logic [BLK_W-1:0] permute(logic [BLK_W-1:0] s, bit inv);
      logic [BLK_W-1:0] t;
      int d;
      for (int i = 0; i < BLK_W; i++) begin
        d = 4*(i/16) + 32*((3*((i%16)/4) + i%4) % 4) + i%4;
        if (inv) begin
          t[i] = s[d];
        end else begin
          t[d] = s[i];
        end
      end
      return t;
    endfunction

    function logic [BLK_W-1:0] add_key(logic [BLK_W-1:0] s, logic [31:0] u,
                                       logic [31:0] v, logic [5:0] c);
      logic [BLK_W-1:0] t;
      t = s;
      for (int i = 0; i < 32; i++) begin
        t[4*i+2] ^= u[i];
        t[4*i+1] ^= v[i];
      end
      for (int i = 0; i < 6; i++) t[4*i+3] ^= c[i];
      t[BLK_W-1] ^= 1'b1;
      return t;
    endfunction

    function block_t gift_crypt(bit act, block_t din);
      logic [15:0] k[8];
      logic [31:0] ru[ROUNDS];
      logic [31:0] rv[ROUNDS];
      logic [5:0] rc[ROUNDS];
      logic [5:0] c;
      logic [15:0] a;
      logic [15:0] b;
      logic [BLK_W-1:0] s;
      c = '0;
      for (int j = 0; j < 4; j++) begin
        k[j] = key_lo[16*j +: 16];
        k[j+4] = key_hi[16*j +: 16];
      end
      // whole key schedule up front so decryption can walk it backwards
      for (int r = 0; r < ROUNDS; r++) begin
        ru[r] = {k[5], k[4]};
        rv[r] = {k[1], k[0]};
        c = {c[4:0], c[5] ^ c[4] ^ 1'b1};
        rc[r] = c;
        a = {k[1][1:0], k[1][15:2]};
        b = {k[0][11:0], k[0][15:12]};
        for (int j = 0; j < 6; j++) k[j] = k[j+2];
        k[7] = a;
        k[6] = b;
      end
      s = din;
      if (act == ACT_ENC) begin
        for (int r = 0; r < ROUNDS; r++) begin
          s = add_key(permute(sub_layer(s, 1'b0), 1'b0), ru[r], rv[r], rc[r]);
        end
      end else begin
        for (int r = ROUNDS - 1; r >= 0; r--) begin
          s = sub_layer(permute(add_key(s, ru[r], rv[r], rc[r]), 1'b1), 1'b1);
        end
      end
      return s;
    endfunction

    function void note_block(bit act, block_t din);
      expected_q.push_back(gift_crypt(act, din));
    endfunction

    function void check_block(block_t got);
      block_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no block pending: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.lo !== want.lo) begin
        $error("result_low: expected %h, actual %h", want.lo, got.lo);
        errors++;
      end
      if (got.hi !== want.hi) begin
        $error("result_high: expected %h, actual %h", want.hi, got.hi);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_action;
  logic [HALF_W-1:0] in_block_low;
  logic [HALF_W-1:0] in_block_high;
  logic out_valid;
  logic [HALF_W-1:0] out_result_low;
  logic [HALF_W-1:0] out_result_high;
  logic cfg_we;
  logic cfg_index;
  logic [HALF_W-1:0] cfg_data;
  int cycle_count = 0;

  gift_scoreboard sb = new();

  gift128_block_cipher #(.ROUNDS(ROUNDS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_block_low(in_block_low),
    .in_block_high(in_block_high),
    .out_valid(out_valid),
    .out_result_low(out_result_low),
    .out_result_high(out_result_high),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result check first so a same-edge input transfer never pairs with itself
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) sb.check_block({out_result_high, out_result_low});
      if (start === 1'b1 && busy === 1'b0) begin
        sb.note_block(in_action, {in_block_high, in_block_low});
      end
      if (cfg_we === 1'b1) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // start stays high between back-to-back blocks, lowered only for a gap or a drain
  task automatic send_block(bit act, block_t din, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_action <= act;
    in_block_low <= din.lo;
    in_block_high <= din.hi;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_key(logic [HALF_W-1:0] klo, logic [HALF_W-1:0] khi);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_data <= klo;
    @(negedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_data <= khi;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [HALF_W-1:0] rand_half();
    logic [HALF_W-1:0] h;
    case ($urandom_range(9))
      0: h = '0;
      1: h = '1;
      2: h = 64'(1) << $urandom_range(63);
      default: h = {$urandom, $urandom};
    endcase
    return h;
  endfunction

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    return $urandom_range(1, $urandom_range(1) ? 4 : 90);
  endfunction

  initial begin
    logic [BLK_W-1:0] pats[6];
    block_t blk;
    bit act;
    int pct;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_ENC;
    in_block_low = '0;
    in_block_high = '0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_LOW;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed blocks under the all-zero key
    pats = '{{BLK_W{1'b0}}, {BLK_W{1'b1}}, {{16{4'h5}}, {16{4'ha}}},
             {{16{4'ha}}, {16{4'h5}}}, 128'h1, {1'b1, 127'h0}};
    load_key('0, '0);
    foreach (pats[i]) begin
      send_block(ACT_ENC, pats[i], 0);
      send_block(ACT_DEC, pats[i], i % 2);
    end
    blk = {rand_half(), rand_half()};
    send_block(ACT_ENC, blk, 0);
    send_block(ACT_DEC, sb.gift_crypt(ACT_ENC, blk), 0);

    // all-ones key
    load_key('1, '1);
    send_block(ACT_ENC, pats[0], 0);
    send_block(ACT_DEC, pats[0], 0);
    send_block(ACT_ENC, pats[1], 3);
    blk = {rand_half(), rand_half()};
    send_block(ACT_ENC, blk, 0);
    send_block(ACT_DEC, sb.gift_crypt(ACT_ENC, blk), 0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: load_key({$urandom, $urandom}, {$urandom, $urandom});
        1: load_key({16{4'h5}}, {16{4'ha}});
        2: load_key('0, '1);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      pct = (p == 1) ? 48 : (p == 3) ? 34 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        act = 1'($urandom_range(1));
        blk = {rand_half(), rand_half()};
        // now and then decrypt a fresh ciphertext to close the round trip
        if ($urandom_range(9) == 0) begin
          act = ACT_DEC;
          blk = sb.gift_crypt(ACT_ENC, blk);
        end
        send_block(act, blk, pick_gap(pct));
        if ($urandom_range(49) == 0) drain();
      end
    end

    drain();
    repeat (2 * ROUNDS + 8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/gift_pkg.sv
src/gift_round.sv
src/gift_keysched.sv
src/gift128_block_cipher.sv
dv/tb.sv
